// ----- rtl/tfb_pkg.sv -----
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants of the tiled framebuffer pixel readback block.
// ----------------------------------------------------------------------------
package tfb_pkg;

	localparam int STORE_WORDS_DEF = 131072;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int COORD_W    = 12;
	localparam int DIM_W      = 11;
	localparam int ADDR_W     = 17;
	localparam int WORD_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int TILE_SHIFT = 3;
	localparam int TILE_BITS  = 2 * TILE_SHIFT;
	localparam int TILE_IDX_W = 2 * (DIM_W - TILE_SHIFT) + 1;
	localparam int OFF_W      = TILE_IDX_W + TILE_BITS;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(240);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(400);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SWAP   = 2'd2,
		REG_ALPHA  = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_STORE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic              rd;
		logic              ok;
		logic [OFF_W-1:0]  addr;
		logic [WORD_W-1:0] data;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             swap;
		logic             alpha_en;
	} cfg_t;

endpackage

// ----- rtl/tfb_if.sv -----
// ----------------------------------------------------------------------------
// tfb_if
// Valid/ready channels of the tiled framebuffer pixel readback block.
// ----------------------------------------------------------------------------
interface tfb_pix_if
	import tfb_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic [ADDR_W-1:0]         store_address;
	logic [WORD_W-1:0]         store_data;
	logic                      last_pixel;

	modport source (output valid, opcode, pos_x, pos_y, store_address,
		store_data, last_pixel, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, store_address,
		store_data, last_pixel, output ready);
endinterface

interface tfb_rgba_if
	import tfb_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;
	logic [BYTE_W-1:0] alpha;
	logic              in_bounds;
	logic              last;

	modport source (output valid, red, green, blue, alpha, in_bounds, last,
		input ready);
	modport sink (input valid, red, green, blue, alpha, in_bounds, last,
		output ready);
endinterface

interface tfb_cfg_if
	import tfb_pkg::*;
	();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tfb_front.sv -----
// ----------------------------------------------------------------------------
// tfb_front
// Holds the configuration registers, accepts items and turns each into a
// command: store words get a range check, read pixels get the axis swap,
// the bounds check and the tiled Morton offset.
// ----------------------------------------------------------------------------
module tfb_front
	import tfb_pkg::*;
	#(
		parameter int STORE_WORDS = STORE_WORDS_DEF
	) (
		input  logic        clk,
		input  logic        arst_n,
		tfb_cfg_if.sink     cfg,
		tfb_pix_if.sink     pix_in,
		input  logic        q_full,
		output logic        push,
		output cmd_t        cmd,
		output cfg_t        cfg_out
	);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             swap_q;
	logic             alpha_q;

	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic                      in_surface;
	logic [DIM_W-1:0]          fy;
	logic [2*(DIM_W-TILE_SHIFT)-1:0] tile_prod;
	logic [TILE_IDX_W-1:0]     tile_idx;
	logic [TILE_BITS-1:0]      morton;
	logic [OFF_W-1:0]          offset;
	logic                      is_read;
	logic [OFF_W-1:0]          st_addr;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			swap_q   <= 1'b1;
			alpha_q  <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				REG_SWAP:   swap_q   <= cfg.data[0];
				REG_ALPHA:  alpha_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign cfg_out = '{width: width_q, height: height_q, swap: swap_q, alpha_en: alpha_q};

	always_comb begin
		px = swap_q ? pix_in.pos_y : pix_in.pos_x;
		py = swap_q ? pix_in.pos_x : pix_in.pos_y;
		in_surface = !px[COORD_W-1] && !py[COORD_W-1]
			&& (px[DIM_W-1:0] < width_q) && (py[DIM_W-1:0] < height_q);
		// Rows are stored bottom up.
		fy = height_q - DIM_W'(1) - py[DIM_W-1:0];
		tile_prod = (2*(DIM_W-TILE_SHIFT))'(fy[DIM_W-1:TILE_SHIFT])
			* (2*(DIM_W-TILE_SHIFT))'(width_q[DIM_W-1:TILE_SHIFT]);
		tile_idx = TILE_IDX_W'(tile_prod) + TILE_IDX_W'(px[DIM_W-1:TILE_SHIFT]);
		for (int b = 0; b < TILE_SHIFT; b++) begin
			morton[2*b]   = px[b];
			morton[2*b+1] = fy[b];
		end
		offset  = {tile_idx, morton};
		st_addr = OFF_W'(pix_in.store_address);
		is_read = (op_t'(pix_in.opcode) == OP_READ);

		cmd.rd   = is_read;
		cmd.ok   = is_read ? (in_surface && (offset < OFF_W'(STORE_WORDS)))
			: (st_addr < OFF_W'(STORE_WORDS));
		cmd.addr = is_read ? offset : st_addr;
		cmd.data = pix_in.store_data;
		cmd.last = pix_in.last_pixel;
	end

	assign pix_in.ready = !q_full;
	assign push        = pix_in.valid && !q_full;

endmodule

// ----- rtl/tfb_queue.sv -----
// ----------------------------------------------------------------------------
// tfb_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tfb_queue
	import tfb_pkg::*;
	#(
		parameter int DEPTH = QUEUE_DEPTH_DEF
	) (
		input  logic clk,
		input  logic arst_n,
		input  logic push,
		input  cmd_t push_cmd,
		output logic full,
		input  logic pop,
		output logic pop_valid,
		output cmd_t pop_cmd
	);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd   = entry_q[rptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/tfb_back.sv -----
// ----------------------------------------------------------------------------
// tfb_back
// Carries out queued commands against the pixel store: stores write one
// word, reads fetch one word, which is split into bytes in the output
// register.
// ----------------------------------------------------------------------------
module tfb_back
	import tfb_pkg::*;
	#(
		parameter int STORE_WORDS = STORE_WORDS_DEF
	) (
		input  logic        clk,
		input  logic        arst_n,
		input  logic        cmd_valid,
		input  cmd_t        cmd,
		output logic        pop,
		input  logic        alpha_en,
		tfb_rgba_if.source  pix_out
	);

	localparam int AW = $clog2(STORE_WORDS);

	logic [WORD_W-1:0] store_mem [STORE_WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic              valid_s1;
	logic              ok_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] red_q;
	logic [BYTE_W-1:0] green_q;
	logic [BYTE_W-1:0] blue_q;
	logic [BYTE_W-1:0] alpha_q;
	logic              in_bounds_q;
	logic              last_q;
	logic              adv_s1;
	logic [AW-1:0]     mem_addr;

	assign adv_s1   = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pop      = cmd_valid && (!valid_s1 || adv_s1);
	assign mem_addr = cmd.addr[AW-1:0];

	// Read data is only captured when a read leaves the queue, so it holds
	// while the read waits in stage one.
	always_ff @(posedge clk) begin
		if (pop && cmd.ok) begin
			if (cmd.rd) begin
				rdata_q <= store_mem[mem_addr];
			end else begin
				store_mem[mem_addr] <= cmd.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ok_s1   <= cmd.ok;
			last_s1 <= cmd.last;
		end
		if (adv_s1) begin
			red_q       <= ok_s1 ? rdata_q[31:24] : '0;
			green_q     <= ok_s1 ? rdata_q[23:16] : '0;
			blue_q      <= ok_s1 ? rdata_q[15:8] : '0;
			alpha_q     <= (ok_s1 && alpha_en) ? rdata_q[7:0] : '0;
			in_bounds_q <= ok_s1;
			last_q      <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= cmd.rd;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.red       = red_q;
	assign pix_out.green     = green_q;
	assign pix_out.blue      = blue_q;
	assign pix_out.alpha     = alpha_q;
	assign pix_out.in_bounds = in_bounds_q;
	assign pix_out.last      = last_q;

endmodule

// ----- rtl/tiled_framebuffer_pixel_readback.sv -----
// ----------------------------------------------------------------------------
// tiled_framebuffer_pixel_readback
// Framebuffer of RGBA8 words in 8x8 Morton tiles with pixel readback.
//
//  channel   dir   carries
//  -------   ---   -----------------------------------------------------
//  pix_in    in    store word (opcode 0) or read logical pixel (opcode 1)
//  pix_out   out   red, green, blue, alpha, in_bounds, last per read item
//  cfg       in    register index and data, always ready
//
// One item is accepted per cycle while the command queue has room. A read
// item passes the queue, stage one and the output register to pix_out; the
// single pixel store port serves one item per cycle unless pix_out stalls.
// Reset restores the register defaults; store contents stay undefined
// until written. A stalled pix_out fills the queue and then stalls pix_in.
// ----------------------------------------------------------------------------
module tiled_framebuffer_pixel_readback
	import tfb_pkg::*;
	#(
		parameter int STORE_WORDS = STORE_WORDS_DEF,
		parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
	) (
		input  logic       clk,
		input  logic       arst_n,
		tfb_pix_if.sink    pix_in,
		tfb_rgba_if.source pix_out,
		tfb_cfg_if.sink    cfg
	);

	logic q_full;
	logic push;
	cmd_t push_cmd;
	cfg_t cfg_cur;
	logic pop;
	logic pop_valid;
	cmd_t pop_cmd;

	tfb_front #(
		.STORE_WORDS(STORE_WORDS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.pix_in  (pix_in),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd),
		.cfg_out (cfg_cur)
	);

	tfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	tfb_back #(
		.STORE_WORDS(STORE_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.pop       (pop),
		.alpha_en  (cfg_cur.alpha_en),
		.pix_out   (pix_out)
	);

endmodule
